>>> hw/rtl/lrb_pkg.sv
package lrb_pkg;

  // width of the timeout and retry configuration registers and of the backoff delay
  localparam int unsigned CfgW = 20;
  localparam int unsigned TimerBitsDef = 20;

  // link modes
  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_CONNECTING = 2'd1;
  localparam logic [1:0] MODE_CONNECTED  = 2'd2;
  localparam logic [1:0] MODE_BACKOFF    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_CREDENTIALS = 2'd0;
  localparam logic [1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_RETRY_MIN   = 2'd2;
  localparam logic [1:0] REG_RETRY_MAX   = 2'd3;

  // request kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // reset values
  localparam logic            CREDENTIALS_RST = 1'b1;
  localparam logic [CfgW-1:0] TIMEOUT_RST     = CfgW'(15000);
  localparam logic [CfgW-1:0] RETRY_MIN_RST   = CfgW'(1000);
  localparam logic [CfgW-1:0] RETRY_MAX_RST   = CfgW'(60000);

  localparam logic signed [7:0] RSSI_OFFLINE = -8'sd100;

  typedef struct packed {
    logic            credentials_set;
    logic [CfgW-1:0] connect_timeout_ms;
    logic [CfgW-1:0] retry_min_ms;
    logic [CfgW-1:0] retry_max_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] rssi_report;
    logic              drive_begin;
    logic              drive_disconnect;
    logic              connected;
    logic [1:0]        link_state;
  } result_t;

endpackage

>>> hw/rtl/lrb_cfg_regs.sv
module lrb_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [lrb_pkg::CfgW-1:0] cfg_data_i,
  output lrb_pkg::cfg_t           cfg_o
);

  lrb_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lrb_pkg::REG_CREDENTIALS: cfg_d.credentials_set    = cfg_data_i[0];
        lrb_pkg::REG_TIMEOUT:     cfg_d.connect_timeout_ms = cfg_data_i;
        lrb_pkg::REG_RETRY_MIN:   cfg_d.retry_min_ms       = cfg_data_i;
        lrb_pkg::REG_RETRY_MAX:   cfg_d.retry_max_ms       = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.credentials_set    <= lrb_pkg::CREDENTIALS_RST;
      cfg_q.connect_timeout_ms <= lrb_pkg::TIMEOUT_RST;
      cfg_q.retry_min_ms       <= lrb_pkg::RETRY_MIN_RST;
      cfg_q.retry_max_ms       <= lrb_pkg::RETRY_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/lrb_step.sv
module lrb_step #(
  parameter int unsigned TIMER_BITS = lrb_pkg::TimerBitsDef
) (
  input  lrb_pkg::cfg_t                  cfg_i,
  input  logic [1:0]                     mode_i,
  input  logic [TIMER_BITS-1:0]          elapsed_i,
  input  logic [lrb_pkg::CfgW-1:0]       backoff_i,
  input  logic                           op_i,
  input  logic                           link_up_i,
  input  logic signed [7:0]              rssi_i,
  output logic [1:0]                     mode_o,
  output logic [TIMER_BITS-1:0]          elapsed_o,
  output logic [lrb_pkg::CfgW-1:0]       backoff_o,
  output lrb_pkg::result_t               res_o
);

  localparam int unsigned CmpW = (TIMER_BITS > lrb_pkg::CfgW) ? TIMER_BITS : lrb_pkg::CfgW;

  logic [TIMER_BITS-1:0]    elapsed_inc;
  logic [CmpW-1:0]          elapsed_ext;
  logic                     timeout_hit;
  logic                     backoff_hit;
  logic [lrb_pkg::CfgW:0]   twice;
  logic [lrb_pkg::CfgW:0]   max_ext;
  logic [lrb_pkg::CfgW-1:0] backoff_next;
  logic                     disc;
  logic                     beg;

  // saturating millisecond counter
  assign elapsed_inc = (elapsed_i != {TIMER_BITS{1'b1}}) ? elapsed_i + TIMER_BITS'(1)
                                                         : elapsed_i;
  assign elapsed_ext = CmpW'(elapsed_inc);
  assign timeout_hit = elapsed_ext >= CmpW'(cfg_i.connect_timeout_ms);
  assign backoff_hit = elapsed_ext >= CmpW'(backoff_i);

  // doubled delay capped at the maximum
  assign twice        = {backoff_i, 1'b0};
  assign max_ext      = {1'b0, cfg_i.retry_max_ms};
  assign backoff_next = (twice < max_ext) ? twice[lrb_pkg::CfgW-1:0] : cfg_i.retry_max_ms;

  always_comb begin
    mode_o    = mode_i;
    elapsed_o = elapsed_i;
    backoff_o = backoff_i;
    disc      = 1'b0;
    beg       = 1'b0;
    if (op_i == lrb_pkg::OP_START) begin
      if (cfg_i.credentials_set) begin
        beg       = 1'b1;
        mode_o    = lrb_pkg::MODE_CONNECTING;
        elapsed_o = '0;
      end else begin
        mode_o = lrb_pkg::MODE_IDLE;
      end
    end else begin
      elapsed_o = elapsed_inc;
      case (mode_i)
        lrb_pkg::MODE_CONNECTING: begin
          if (link_up_i) begin
            mode_o    = lrb_pkg::MODE_CONNECTED;
            backoff_o = cfg_i.retry_min_ms;
          end else if (timeout_hit) begin
            disc      = 1'b1;
            mode_o    = lrb_pkg::MODE_BACKOFF;
            elapsed_o = '0;
          end
        end
        lrb_pkg::MODE_CONNECTED: begin
          if (!link_up_i) begin
            mode_o    = lrb_pkg::MODE_BACKOFF;
            elapsed_o = '0;
          end
        end
        lrb_pkg::MODE_BACKOFF: begin
          if (backoff_hit) begin
            disc      = 1'b1;
            beg       = 1'b1;
            mode_o    = lrb_pkg::MODE_CONNECTING;
            elapsed_o = '0;
            backoff_o = backoff_next;
          end
        end
        default: begin
          mode_o = mode_i;
        end
      endcase
    end
  end

  always_comb begin
    res_o.link_state       = mode_o;
    res_o.connected        = (mode_o == lrb_pkg::MODE_CONNECTED);
    res_o.drive_disconnect = disc;
    res_o.drive_begin      = beg;
    res_o.rssi_report      = (mode_o == lrb_pkg::MODE_CONNECTED) ? rssi_i
                                                                  : lrb_pkg::RSSI_OFFLINE;
  end

endmodule

>>> hw/rtl/link_reconnect_backoff_fsm.sv
// channel   | dir | signals                          | contents
// s_axis    | in  | tvalid tready tdata[15:0] tuser  | tick or start word, link status, rssi
// m_axis    | out | tvalid tready tdata[15:0]        | mode, pulses, reported rssi
// cfg       | in  | cfg_we_i cfg_idx_i cfg_data_i    | register writes, no read-back
//
// one word per cycle sustained while m_axis is not stalled; each word passes through
// the input register and leaves from the result register
// the mode/timer/backoff update is one pass of compare, doubling and select logic
// rst_ni is asynchronous active low: mode idle, timer zero, backoff at its minimum
// a stalled m_axis holds its word; s_axis keeps accepting while the input register
// can drain into the result register
module link_reconnect_backoff_fsm #(
  parameter int unsigned TIMER_BITS = lrb_pkg::TimerBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] link_up, [8:1] rssi_sample, [15:9] zero
  input  logic [15:0]              s_axis_tdata,
  // [0] op: 0 tick, 1 start
  input  logic                     s_axis_tuser,

  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] link_state, [2] connected, [3] drive_disconnect, [4] drive_begin,
  // [12:5] rssi_report, [15:13] zero
  output logic [15:0]              m_axis_tdata,

  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [lrb_pkg::CfgW-1:0] cfg_data_i
);

  lrb_pkg::cfg_t cfg;

  // input register
  logic              in_valid_q;
  logic              in_op_q;
  logic              in_up_q;
  logic signed [7:0] in_rssi_q;

  // supervisor state
  logic [1:0]               mode_d, mode_q;
  logic [TIMER_BITS-1:0]    elapsed_d, elapsed_q;
  logic [lrb_pkg::CfgW-1:0] backoff_d, backoff_q;

  // result register
  logic             out_valid_q;
  lrb_pkg::result_t res_d, res_q;

  logic advance;
  logic fire;

  lrb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lrb_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg_i     (cfg),
    .mode_i    (mode_q),
    .elapsed_i (elapsed_q),
    .backoff_i (backoff_q),
    .op_i      (in_op_q),
    .link_up_i (in_up_q),
    .rssi_i    (in_rssi_q),
    .mode_o    (mode_d),
    .elapsed_o (elapsed_d),
    .backoff_o (backoff_d),
    .res_o     (res_d)
  );

  // result slot frees when empty or taken this cycle
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_up_q   <= s_axis_tdata[0];
      in_rssi_q <= s_axis_tdata[8:1];
    end
  end

  // state commits only when the word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lrb_pkg::MODE_IDLE;
      elapsed_q <= '0;
      backoff_q <= lrb_pkg::RETRY_MIN_RST;
    end else if (fire) begin
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      backoff_q <= backoff_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

endmodule

>>> hw/rtl/lrb_checker.sv
module lrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // online flag and reported rssi follow the mode
  a_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[2] == (m_axis_tdata[1:0] == lrb_pkg::MODE_CONNECTED)) &&
      (m_axis_tdata[2] || (m_axis_tdata[12:5] == lrb_pkg::RSSI_OFFLINE)))
    else $error("online flag or rssi inconsistent with mode");

  // a begin pulse always lands in connecting
  a_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[1:0] == lrb_pkg::MODE_CONNECTING)
    else $error("begin pulse outside connecting");

  // a lone disconnect is a timeout and lands in backoff
  a_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] && !m_axis_tdata[4] |->
      m_axis_tdata[1:0] == lrb_pkg::MODE_BACKOFF)
    else $error("disconnect pulse without backoff");

endmodule

bind link_reconnect_backoff_fsm lrb_checker u_lrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
